/* rtl/ndtag_pkg.sv */
package ndtag_pkg;

   localparam int REG_W           = 13;
   localparam int IDX_W           = 48;
   localparam int NUM_REGS        = 4;
   localparam int CSR_ADDR_W      = 3;
   localparam int MAX_DIMS_DEF    = 4;
   localparam int EXTENT_BITS_DEF = 12;

   localparam logic [CSR_ADDR_W-1:0] CSR_EXTENT_DIM0 = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_EXTENT_DIM1 = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_EXTENT_DIM2 = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_EXTENT_DIM3 = 3'd3;

   localparam logic [REG_W-1:0] EXTENT_RESET = 13'd1;

   typedef struct packed {
      logic [IDX_W-1:0] read_index;
      logic [IDX_W-1:0] write_index;
      logic             last;
   } rsp_type;

endpackage

/* rtl/ndtag_setup.sv */
module ndtag_setup #(
   parameter int MAX_DIMS    = ndtag_pkg::MAX_DIMS_DEF,
   parameter int EXTENT_BITS = ndtag_pkg::EXTENT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cfg_write,
   input  logic [EXTENT_BITS:0]        eff [MAX_DIMS],
   output logic [ndtag_pkg::IDX_W-1:0] stride [MAX_DIMS],
   output logic                        busy,
   output logic [MAX_DIMS-1:0]         rebuild_sel
);

   localparam int EW     = EXTENT_BITS + 1;
   localparam int MW     = ndtag_pkg::IDX_W + EW;
   localparam int SETTLE = 2 * MAX_DIMS + 1;
   localparam int CNT_W  = $clog2(SETTLE + 1);

   logic [ndtag_pkg::IDX_W-1:0] stride_ff [MAX_DIMS];
   logic [ndtag_pkg::IDX_W-1:0] stride_in [MAX_DIMS];
   logic [CNT_W-1:0]            cnt_ff;
   logic [CNT_W-1:0]            cnt_in;

   // stride chain settles one dimension per cycle, last dimension first
   for (genvar d = 0; d < MAX_DIMS; d++) begin : g_stride
      if (d == MAX_DIMS - 1) begin : g_top
         assign stride_in[d] = ndtag_pkg::IDX_W'(1);
      end else begin : g_mul
         logic [MW-1:0] mul;
         assign mul          = MW'(stride_ff[d+1]) * MW'(eff[d+1]);
         assign stride_in[d] = mul[ndtag_pkg::IDX_W-1:0];
      end
      assign rebuild_sel[d] = (cnt_ff == CNT_W'(d + 1));
   end

   always_comb begin
      if (cfg_write) begin
         cnt_in = CNT_W'(SETTLE);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= CNT_W'(SETTLE);
      end else begin
         cnt_ff <= cnt_in;
      end
      stride_ff <= stride_in;
   end

   assign stride = stride_ff;
   assign busy   = (cnt_ff != '0);

endmodule

/* rtl/ndtag_core.sv */
module ndtag_core #(
   parameter int MAX_DIMS    = ndtag_pkg::MAX_DIMS_DEF,
   parameter int EXTENT_BITS = ndtag_pkg::EXTENT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        restart,
   input  logic [EXTENT_BITS:0]        eff [MAX_DIMS],
   input  logic [ndtag_pkg::IDX_W-1:0] stride [MAX_DIMS],
   input  logic [MAX_DIMS-1:0]         rebuild_sel,
   output ndtag_pkg::rsp_type          result
);

   localparam int EW = EXTENT_BITS + 1;
   localparam int IW = ndtag_pkg::IDX_W;
   localparam int PW = IW + EXTENT_BITS;

   logic [EXTENT_BITS-1:0] coord_ff [MAX_DIMS];
   logic [EXTENT_BITS-1:0] coord_in [MAX_DIMS];
   logic [IW-1:0]          sum_ff   [MAX_DIMS];
   logic [IW-1:0]          sum_in   [MAX_DIMS];
   logic [IW-1:0]          prod_ff  [MAX_DIMS];
   logic [IW-1:0]          prod_in  [MAX_DIMS];
   logic [IW-1:0]          upper    [MAX_DIMS];
   logic [IW-1:0]          wcount_ff;
   logic [IW-1:0]          wcount_in;

   logic [EXTENT_BITS-1:0] cur_coord [MAX_DIMS];
   logic [IW-1:0]          cur_sum   [MAX_DIMS];
   logic [EW-1:0]          nxt       [MAX_DIMS];
   logic [MAX_DIMS-1:0]    wrapd;
   logic [MAX_DIMS-1:0]    incr;
   logic [MAX_DIMS:0]      carry;
   logic [IW-1:0]          sel_sum;
   logic [IW-1:0]          sel_stride;
   logic [IW-1:0]          bump;
   logic [IW-1:0]          write_now;

   // sum_ff[d] holds the read offset carried by dimensions d and above;
   // prod/upper rebuild it top-down after the strides change
   for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
      logic [PW-1:0] mul;
      assign mul        = PW'(coord_ff[d]) * PW'(stride[d]);
      assign prod_in[d] = mul[IW-1:0];
      if (d == MAX_DIMS - 1) begin : g_top
         assign upper[d] = '0;
      end else begin : g_mid
         assign upper[d] = sum_ff[d+1];
      end
   end

   always_comb begin
      carry[0]   = 1'b1;
      sel_sum    = '0;
      sel_stride = '0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         cur_coord[d] = restart ? '0 : coord_ff[d];
         cur_sum[d]   = restart ? '0 : sum_ff[d];
         nxt[d]       = EW'(cur_coord[d]) + EW'(1);
         wrapd[d]     = (nxt[d] >= eff[d]);
         incr[d]      = carry[d] & ~wrapd[d];
         carry[d+1]   = carry[d] & wrapd[d];
         if (incr[d]) begin
            sel_sum    = sel_sum | cur_sum[d];
            sel_stride = sel_stride | stride[d];
         end
      end
      bump      = sel_sum + sel_stride;
      write_now = restart ? '0 : wcount_ff;

      result.read_index  = cur_sum[0];
      result.write_index = write_now;
      result.last        = carry[MAX_DIMS];

      coord_in  = coord_ff;
      sum_in    = sum_ff;
      wcount_in = wcount_ff;
      if (accept) begin
         for (int j = 0; j < MAX_DIMS; j++) begin
            if (carry[j]) begin
               coord_in[j] = incr[j] ? nxt[j][EXTENT_BITS-1:0] : '0;
               sum_in[j]   = carry[MAX_DIMS] ? '0 : bump;
            end else begin
               coord_in[j] = cur_coord[j];
               sum_in[j]   = cur_sum[j];
            end
         end
         wcount_in = carry[MAX_DIMS] ? '0 : write_now + IW'(1);
      end else begin
         for (int j = 0; j < MAX_DIMS; j++) begin
            if (rebuild_sel[j]) begin
               sum_in[j] = upper[j] + prod_ff[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coord_ff  <= '{default: '0};
         wcount_ff <= '0;
      end else begin
         coord_ff  <= coord_in;
         wcount_ff <= wcount_in;
      end
      sum_ff  <= sum_in;
      prod_ff <= prod_in;
   end

endmodule

/* rtl/ndtag_skid.sv */
module ndtag_skid (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ndtag_pkg::rsp_type din,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output ndtag_pkg::rsp_type dout,
   output logic               full
);

   ndtag_pkg::rsp_type main_ff;
   ndtag_pkg::rsp_type main_in;
   ndtag_pkg::rsp_type skid_ff;
   ndtag_pkg::rsp_type skid_in;
   logic               main_valid_ff;
   logic               main_valid_in;
   logic               skid_valid_ff;
   logic               skid_valid_in;
   logic               take;

   assign take = main_valid_ff & ~rsp_stall;

   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || take) begin
            main_in       = din;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = din;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = main_valid_ff;
   assign dout      = main_ff;
   assign full      = skid_valid_ff;

endmodule

/* rtl/nd_transpose_address_gen.sv */
// A request's addresses are registered into the output buffer when it is accepted
// and then appear on rsp_. Throughput: one request per cycle while req_stall is
// low; a two-entry output buffer absorbs rsp_stall. After reset and after every
// csr write, requests are stalled while the stride chain (one multiplier per
// dimension but the last) and the partial read offsets are rebuilt. Reset is
// synchronous: extents return to 1, the coordinate counter and write count to zero.
module nd_transpose_address_gen #(
   parameter int MAX_DIMS    = ndtag_pkg::MAX_DIMS_DEF,
   parameter int EXTENT_BITS = ndtag_pkg::EXTENT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_restart,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ndtag_pkg::IDX_W-1:0]      rsp_read_index,
   output logic [ndtag_pkg::IDX_W-1:0]      rsp_write_index,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ndtag_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [ndtag_pkg::REG_W-1:0]      csr_data
);

   localparam int EW = EXTENT_BITS + 1;
   localparam int CW = (ndtag_pkg::REG_W > EW) ? ndtag_pkg::REG_W : EW;
   localparam logic [CW-1:0] EXT_LIMIT = CW'(1) << EXTENT_BITS;

   logic [ndtag_pkg::REG_W-1:0] extent_ff [ndtag_pkg::NUM_REGS];
   logic [ndtag_pkg::REG_W-1:0] extent_in [ndtag_pkg::NUM_REGS];
   logic [EW-1:0]               eff       [MAX_DIMS];
   logic [ndtag_pkg::IDX_W-1:0] stride    [MAX_DIMS];
   logic [MAX_DIMS-1:0]         rebuild_sel;
   logic                        busy;
   logic                        cfg_write;
   logic                        req_accept;
   logic                        skid_full;
   ndtag_pkg::rsp_type          core_rsp;
   ndtag_pkg::rsp_type          out_rsp;

   assign csr_ready  = 1'b1;
   assign cfg_write  = csr_valid & csr_ready;
   assign req_stall  = skid_full | busy;
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      extent_in = extent_ff;
      if (cfg_write) begin
         case (csr_index)
            ndtag_pkg::CSR_EXTENT_DIM0: extent_in[0] = csr_data;
            ndtag_pkg::CSR_EXTENT_DIM1: extent_in[1] = csr_data;
            ndtag_pkg::CSR_EXTENT_DIM2: extent_in[2] = csr_data;
            ndtag_pkg::CSR_EXTENT_DIM3: extent_in[3] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         extent_ff <= '{default: ndtag_pkg::EXTENT_RESET};
      end else begin
         extent_ff <= extent_in;
      end
   end

   // zero reads as one, oversize clamps to 2^EXTENT_BITS, missing dimensions are one
   for (genvar d = 0; d < MAX_DIMS; d++) begin : g_eff
      if (d < ndtag_pkg::NUM_REGS) begin : g_reg
         logic [CW-1:0] ext_wide;
         assign ext_wide = CW'(extent_ff[d]);
         assign eff[d]   = (ext_wide == '0)       ? EW'(1) :
                           (ext_wide > EXT_LIMIT) ? EW'(EXT_LIMIT) : EW'(ext_wide);
      end else begin : g_pad
         assign eff[d] = EW'(1);
      end
   end

   ndtag_setup #(
      .MAX_DIMS    (MAX_DIMS),
      .EXTENT_BITS (EXTENT_BITS)
   ) u_setup (
      .clock       (clock),
      .reset       (reset),
      .cfg_write   (cfg_write),
      .eff         (eff),
      .stride      (stride),
      .busy        (busy),
      .rebuild_sel (rebuild_sel)
   );

   ndtag_core #(
      .MAX_DIMS    (MAX_DIMS),
      .EXTENT_BITS (EXTENT_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .restart     (req_restart),
      .eff         (eff),
      .stride      (stride),
      .rebuild_sel (rebuild_sel),
      .result      (core_rsp)
   );

   ndtag_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .din       (core_rsp),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .dout      (out_rsp),
      .full      (skid_full)
   );

   assign rsp_read_index  = out_rsp.read_index;
   assign rsp_write_index = out_rsp.write_index;
   assign rsp_last        = out_rsp.last;

`ifndef SYNTHESIS
   a_cfg_holds_off: assert property (@(posedge clock) disable iff (reset)
      cfg_write |=> req_stall)
      else $error("request not held off after csr write");

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_full |-> rsp_valid)
      else $error("skid entry held with output empty");

   a_restart_zero: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_restart |-> core_rsp.read_index == '0 &&
      core_rsp.write_index == '0)
      else $error("restart request did not start at zero");

   a_request_lands: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("accepted request produced no response");
`endif

endmodule
